// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the rigid body integrator. Expect clk_i and rst_ni
// in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion, off during reset
`define RBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define RBI_ASSERT_IMP(lbl, ante, cons, msg) \
  `RBI_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define RBI_ASSERT_NXT(lbl, ante, cons, msg) \
  `RBI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// Types, constants and fixed-point helpers of the rigid body integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

  localparam int NUM_BODIES_DEF = 64;
  localparam int FRAC_BITS      = 16;
  localparam int ONE_FX         = 1 << FRAC_BITS;
  localparam int HALF_FX        = 1 << (FRAC_BITS - 1);

  localparam int PROD_W   = 66;
  localparam int ITER_W   = 5;
  localparam int ITER_N   = 1 << ITER_W;
  localparam int NUM_OPS  = 14;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(HALF_FX);
  localparam logic signed [PROD_W-1:0] W_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] W_MIN = -66'sd2147483648;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  localparam logic CMD_RESET     = 1'b0;
  localparam logic CMD_INTEGRATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TIME_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_DAMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_DAMP      = 3'd5;

  typedef enum logic [3:0] {
    OP_ACC_X, OP_ACC_Y, OP_ACC_W,
    OP_DEL_X, OP_DEL_Y, OP_DEL_W,
    OP_DMP_X, OP_DMP_Y, OP_DMP_W,
    OP_LIM_T, OP_LIM_R,
    OP_SQ_X, OP_SQ_Y, OP_LIM_T2,
    OP_SCL_X, OP_SCL_Y
  } rbi_op_e;

  typedef struct packed {
    logic               command;
    logic [5:0]         body_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] torque;
    logic signed [31:0] impulse_vx;
    logic signed [31:0] impulse_vy;
    logic signed [31:0] impulse_w;
    logic [30:0]        inverse_mass;
    logic [30:0]        inverse_inertia;
  } rbi_in_t;

  typedef struct packed {
    logic [5:0]         out_body;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_ang_vel;
    logic signed [31:0] out_orient;
  } rbi_out_t;

  typedef struct packed {
    logic [16:0] time_step;
    logic [30:0] inverse_time_step;
    logic [30:0] max_step_translation;
    logic [30:0] max_step_rotation;
    logic [16:0] trans_damping;
    logic [16:0] angular_damping;
  } rbi_cfg_t;

  localparam rbi_cfg_t CFG_RST = '{
    time_step:            17'd1092,
    inverse_time_step:    31'd3932160,
    max_step_translation: 31'd131072,
    max_step_rotation:    31'd51472,
    trans_damping:        17'd0,
    angular_damping:      17'd0
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic signed [31:0] angle;
  } rbi_row_t;

  typedef struct packed {
    logic    clr_we;
    logic    cap;
    logic    load;
    logic    mul_go;
    rbi_op_e mul_op;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    div_step;
    logic    div_wb;
    logic    axis;
    logic    rot_apply;
    logic    pos_upd;
    logic    commit;
  } rbi_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic integrate;
    logic in_range;
    logic clamp_lin;
    logic out_free;
  } rbi_sts_t;

  function automatic logic signed [31:0] sat_w(input logic signed [PROD_W-1:0] v);
    if (v > W_MAX) return S32_MAX;
    if (v < W_MIN) return S32_MIN;
    return v[31:0];
  endfunction

  // product rounded to nearest, ties up, then saturated
  function automatic logic signed [31:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND_HALF) >>> FRAC_BITS;
    return sat_w(t);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [PROD_W-1:0] s;
    s = PROD_W'(a) + PROD_W'(b);
    return sat_w(s);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [31:0] m);
    logic signed [PROD_W-1:0] v;
    v = $signed(PROD_W'(m));
    if (neg) v = -v;
    return sat_w(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rigid_body_integrator.sv =====
// ----------------------------------------------------------------------------
// rigid_body_integrator
// 2D rigid body state table with semi-implicit Euler tick, Q16.16.
//
//   port group   dir  handshake              word
//   in_*         in   in_valid_i/in_stall_o  rbi_in_t, one command
//   out_*        out  out_valid_o/out_stall_i rbi_out_t, one body state
//   cfg_*        in   cfg_valid_i/cfg_ready_o index + 32 bit data
//
// Reset or out of range index: the command goes from load straight to commit.
// Integrate: the multiply schedule, then with the speed clamp engaged the
//   32-step square root and two 32-step divisions before commit.
// After reset a clear pass zeros every row of the state memory; input
//   stalls meanwhile.
// A finished word waits in the output register; a stalled output holds
//   the next result back only at its commit.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_integrator import rbi_pkg::*; #(
  parameter int NUM_BODIES = NUM_BODIES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire rbi_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rbi_out_t                  out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  rbi_cfg_t cfg_q;
  rbi_cmd_t cmd;
  rbi_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIME_STEP:     cfg_q.time_step            <= cfg_data_i[16:0];
        CFG_INV_TIME_STEP: cfg_q.inverse_time_step    <= cfg_data_i[30:0];
        CFG_MAX_TRANS:     cfg_q.max_step_translation <= cfg_data_i[30:0];
        CFG_MAX_ROT:       cfg_q.max_step_rotation    <= cfg_data_i[30:0];
        CFG_LIN_DAMP:      cfg_q.trans_damping        <= cfg_data_i[16:0];
        CFG_ANG_DAMP:      cfg_q.angular_damping      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  rbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbi_dpath #(
    .NUM_BODIES (NUM_BODIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbi_ctrl
// Sequencer of the integrator: memory clear, load, multiply schedule,
// square root, two divisions, clamp, position update, commit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbi_ctrl import rbi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire rbi_sts_t sts_i,
  output rbi_cmd_t      cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_WBL   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_DLD   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DWB   = 4'd10;
  localparam logic [3:0] S_ROT   = 4'd11;
  localparam logic [3:0] S_POS   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              axis_q, axis_d;
  logic              iter_last;

  assign iter_last  = (cnt_q == ITER_W'(ITER_N - 1));
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = (sts_i.integrate && sts_i.in_range) ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = rbi_op_e'(cnt_q[3:0]);
        if (cnt_q == ITER_W'(NUM_OPS - 1)) state_d = S_WBL;
        else cnt_d = cnt_q + 1'b1;
      end
      S_WBL: state_d = S_CHK;
      S_CHK: begin
        cnt_d  = '0;
        axis_d = 1'b0;
        if (sts_i.clamp_lin) begin
          cmd_o.sqrt_init = 1'b1;
          state_d         = S_SQRT;
        end else begin
          state_d = S_ROT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (iter_last) state_d = S_SMUL;
        else cnt_d = cnt_q + 1'b1;
      end
      S_SMUL: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = axis_q ? OP_SCL_Y : OP_SCL_X;
        cnt_d        = '0;
        state_d      = S_DLD;
      end
      S_DLD: state_d = S_DIV;
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (iter_last) state_d = S_DWB;
        else cnt_d = cnt_q + 1'b1;
      end
      S_DWB: begin
        cmd_o.div_wb = 1'b1;
        cmd_o.axis   = axis_q;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_SMUL;
        end else begin
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        cmd_o.rot_apply = 1'b1;
        state_d         = S_POS;
      end
      S_POS: begin
        cmd_o.pos_upd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  `RBI_ASSERT_NXT(a_accept_load, in_valid_i && !in_stall_o, state_q == S_LOAD, "accept not followed by load")
  `RBI_ASSERT_IMP(a_div_clamp, state_q == S_DIV || state_q == S_SQRT, sts_i.clamp_lin, "divider running without clamp")

endmodule

`default_nettype wire

// ===== rtl/rbi_dpath.sv =====
// ----------------------------------------------------------------------------
// rbi_dpath
// Body state memory, shared 33x33 multiplier, bit-serial square root and
// divider, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbi_dpath import rbi_pkg::*; #(
  parameter int NUM_BODIES = NUM_BODIES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rbi_in_t  in_data_i,
  input  wire rbi_cfg_t cfg_i,
  input  wire rbi_cmd_t cmd_i,
  output rbi_sts_t      sts_o,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output rbi_out_t      out_data_o
);

  localparam int AW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

  rbi_row_t mem_q [NUM_BODIES];
  rbi_row_t rd_q;
  rbi_row_t wr_row;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] rd_addr, wr_addr;

  rbi_in_t item_q;
  rbi_out_t out_q;
  logic out_vld_q;
  logic in_range;

  logic signed [31:0] px_q, py_q, vx_q, vy_q, w_q, ang_q;
  logic signed [31:0] accx_q, accy_q, accw_q, dx_q, dy_q, dw_q;
  logic [31:0] limt_q, limr_q;
  logic limt_ok_q, limr_ok_q, clamp_lin_q;
  logic [63:0] sq_q;

  logic signed [32:0] op_a, op_b, lfac, afac;
  logic signed [PROD_W-1:0] prod, p_q;
  logic wb_vld_q;
  rbi_op_e wb_op_q;
  logic signed [31:0] rs;
  logic [63:0] lim_raw;

  logic [63:0] sx_q, sr_q, sb_q, st;
  logic [31:0] rem_q, dvd_q;
  logic [32:0] dt;
  logic [31:0] mw;

  assign rd_addr  = AW'(in_data_i.body_index);
  assign wr_addr  = AW'(item_q.body_index);
  assign in_range = (32'(item_q.body_index) < 32'(NUM_BODIES));
  assign wr_row   = '{pos_x: px_q, pos_y: py_q, vel_x: vx_q, vel_y: vy_q,
                      spin: w_q, angle: ang_q};

  assign sts_o.clr_last  = (clr_q == AW'(NUM_BODIES - 1));
  assign sts_o.integrate = (item_q.command == CMD_INTEGRATE);
  assign sts_o.in_range  = in_range;
  assign sts_o.clamp_lin = clamp_lin_q;
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) mem_q[clr_q] <= '0;
    else if (cmd_i.commit && in_range) mem_q[wr_addr] <= wr_row;
    if (cmd_i.cap) rd_q <= mem_q[rd_addr];
  end

  assign lfac = 33'(ONE_FX) - 33'(cfg_i.trans_damping);
  assign afac = 33'(ONE_FX) - 33'(cfg_i.angular_damping);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      OP_ACC_X: begin op_a = 33'(item_q.force_x); op_b = 33'(item_q.inverse_mass); end
      OP_ACC_Y: begin op_a = 33'(item_q.force_y); op_b = 33'(item_q.inverse_mass); end
      OP_ACC_W: begin op_a = 33'(item_q.torque);  op_b = 33'(item_q.inverse_inertia); end
      OP_DEL_X: begin op_a = 33'(accx_q); op_b = 33'(cfg_i.time_step); end
      OP_DEL_Y: begin op_a = 33'(accy_q); op_b = 33'(cfg_i.time_step); end
      OP_DEL_W: begin op_a = 33'(accw_q); op_b = 33'(cfg_i.time_step); end
      OP_DMP_X: begin op_a = 33'(vx_q); op_b = lfac; end
      OP_DMP_Y: begin op_a = 33'(vy_q); op_b = lfac; end
      OP_DMP_W: begin op_a = 33'(w_q);  op_b = afac; end
      OP_LIM_T: begin
        op_a = 33'(cfg_i.max_step_translation);
        op_b = 33'(cfg_i.inverse_time_step);
      end
      OP_LIM_R: begin
        op_a = 33'(cfg_i.max_step_rotation);
        op_b = 33'(cfg_i.inverse_time_step);
      end
      OP_SQ_X:   begin op_a = {1'b0, mag32(vx_q)}; op_b = {1'b0, mag32(vx_q)}; end
      OP_SQ_Y:   begin op_a = {1'b0, mag32(vy_q)}; op_b = {1'b0, mag32(vy_q)}; end
      OP_LIM_T2: begin op_a = {1'b0, limt_q}; op_b = {1'b0, limt_q}; end
      OP_SCL_X:  begin op_a = {1'b0, mag32(vx_q)}; op_b = {1'b0, limt_q}; end
      OP_SCL_Y:  begin op_a = {1'b0, mag32(vy_q)}; op_b = {1'b0, limt_q}; end
      default: ;
    endcase
  end

  assign prod    = op_a * op_b;
  assign rs      = rnd_sat(p_q);
  assign lim_raw = (p_q[63:0] + 64'(HALF_FX)) >> FRAC_BITS;
  assign st      = sr_q | sb_q;
  assign dt      = {rem_q, dvd_q[31]};
  assign mw      = mag32(w_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) item_q <= in_data_i;
    if (cmd_i.mul_go) begin
      p_q     <= prod;
      wb_op_q <= cmd_i.mul_op;
    end
    if (cmd_i.load) begin
      ang_q <= rd_q.angle;
      if (item_q.command == CMD_RESET) begin
        px_q <= item_q.start_x;
        py_q <= item_q.start_y;
        vx_q <= '0;
        vy_q <= '0;
        w_q  <= '0;
      end else begin
        px_q <= rd_q.pos_x;
        py_q <= rd_q.pos_y;
        vx_q <= rd_q.vel_x;
        vy_q <= rd_q.vel_y;
        w_q  <= rd_q.spin;
      end
    end
    if (wb_vld_q) begin
      case (wb_op_q)
        OP_ACC_X: accx_q <= rs;
        OP_ACC_Y: accy_q <= rs;
        OP_ACC_W: accw_q <= rs;
        OP_DEL_X: dx_q <= sat_add(item_q.impulse_vx, rs);
        OP_DEL_Y: dy_q <= sat_add(item_q.impulse_vy, rs);
        OP_DEL_W: dw_q <= sat_add(item_q.impulse_w, rs);
        OP_DMP_X: vx_q <= sat_add(rs, dx_q);
        OP_DMP_Y: vy_q <= sat_add(rs, dy_q);
        OP_DMP_W: w_q  <= sat_add(rs, dw_q);
        OP_LIM_T: begin
          limt_q    <= lim_raw[31:0];
          limt_ok_q <= (lim_raw[63:32] == '0);
        end
        OP_LIM_R: begin
          limr_q    <= lim_raw[31:0];
          limr_ok_q <= (lim_raw[63:32] == '0);
        end
        OP_SQ_X:   sq_q <= p_q[63:0];
        OP_SQ_Y:   sq_q <= sq_q + p_q[63:0];
        OP_LIM_T2: clamp_lin_q <= limt_ok_q && (sq_q > p_q[63:0]);
        OP_SCL_X, OP_SCL_Y: begin
          rem_q <= p_q[63:32];
          dvd_q <= p_q[31:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.sqrt_init) begin
      sx_q <= sq_q;
      sr_q <= '0;
      sb_q <= 64'(1) << 62;
    end
    if (cmd_i.sqrt_step) begin
      if (sx_q >= st) begin
        sx_q <= sx_q - st;
        sr_q <= (sr_q >> 1) | sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q <= sb_q >> 2;
    end
    if (cmd_i.div_step) begin
      if (dt >= {1'b0, sr_q[31:0]}) begin
        rem_q <= 32'(dt - {1'b0, sr_q[31:0]});
        dvd_q <= {dvd_q[30:0], 1'b1};
      end else begin
        rem_q <= dt[31:0];
        dvd_q <= {dvd_q[30:0], 1'b0};
      end
    end
    if (cmd_i.div_wb) begin
      if (cmd_i.axis) vy_q <= sat_mag(vy_q[31], dvd_q);
      else vx_q <= sat_mag(vx_q[31], dvd_q);
    end
    if (cmd_i.rot_apply && limr_ok_q && (mw > limr_q)) w_q <= sat_mag(w_q[31], limr_q);
    if (cmd_i.pos_upd) begin
      px_q  <= sat_add(px_q, vx_q);
      py_q  <= sat_add(py_q, vy_q);
      ang_q <= sat_add(ang_q, w_q);
    end
    if (cmd_i.commit) begin
      out_q.out_body    <= item_q.body_index;
      out_q.out_pos_x   <= in_range ? px_q : '0;
      out_q.out_pos_y   <= in_range ? py_q : '0;
      out_q.out_vel_x   <= in_range ? vx_q : '0;
      out_q.out_vel_y   <= in_range ? vy_q : '0;
      out_q.out_ang_vel <= in_range ? w_q : '0;
      out_q.out_orient  <= in_range ? ang_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + 1'b1;
      wb_vld_q <= cmd_i.mul_go;
      if (cmd_i.commit) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  `RBI_ASSERT_IMP(a_div_bound, wb_vld_q && (wb_op_q == OP_SCL_X || wb_op_q == OP_SCL_Y), p_q[63:32] < sr_q[31:0], "quotient would overflow")
  `RBI_ASSERT_NXT(a_commit_out, cmd_i.commit, out_vld_q, "commit lost")

endmodule

`default_nettype wire
